[rtl/core/assert_macros.svh]
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication across reset");

`endif

[rtl/core/gfcr_pkg.sv]
package gfcr_pkg;

  // Beat codes carried in the input tuser bit.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] GAP_RESET       = 16'd20;
  localparam logic [15:0] IDLE_MAX        = 16'hFFFF;
  localparam int          MIN_FRAME_BYTES = 4;
  localparam int          MAX_FRAME_BYTES_DEFAULT = 64;
  localparam int          OUT_TDATA_W     = 40;

  // One accepted input beat.
  typedef struct packed {
    logic       opcode;
    logic [7:0] byte_value;
  } gfcr_item_t;

  // One closed-frame report.
  typedef struct packed {
    logic        crc_ok;
    logic [6:0]  frame_length;
    logic [15:0] crc_received;
    logic [15:0] crc_computed;
  } gfcr_result_t;

  // Reflected CRC-16 update by one byte, eight shift steps.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/gap_framed_crc16_receiver_top.sv]
// Frame receiver that splits a byte stream into frames by idle gaps and
// checks each frame's trailing Modbus-style CRC-16 (reflected, 0xA001).
// Input stream: each beat is either a received byte (tuser = 0, byte in
// tdata) or a one millisecond tick (tuser = 1, tdata ignored).
// Output stream: one beat per closed frame with length, received CRC,
// computed CRC in tdata and the CRC match flag in tuser.
// A frame closes on the tick at which the idle count reaches cfg gap_ticks
// while at least four bytes are held; shorter fragments join the next frame.
// Bytes beyond MAX_FRAME_BYTES are dropped but still restart the idle count.
// Throughput is one beat per cycle while the output buffer has room: the CRC
// byte update is combinational XOR logic between the input register and the output buffer.
// A closing tick waits in the input register; its report is registered into the
// output buffer, whose head entry drives the output.
// Reset clears the frame state, restores gap_ticks to 20 and empties both
// stages. When the output is stalled, two reports are held; after that the
// input tready drops until a report is taken.
module gap_framed_crc16_receiver_top
  import gfcr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_wdata,      // gap_ticks
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] byte_value
  input  logic                   s_axis_tuser,   // [0] opcode
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [6:0] frame_length, [22:7] crc_received,
                                                 // [38:23] crc_computed, [39] zero
  output logic                   m_axis_tuser    // [0] crc_ok
);

  logic         item_valid;
  gfcr_item_t   item;
  logic         room;
  logic         fire;
  logic         push;
  gfcr_result_t result;

  // A registered beat is processed whenever the output buffer has room.
  assign fire = item_valid && room;

  gfcr_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take          (fire),
    .item_valid    (item_valid),
    .item          (item)
  );

  gfcr_frame_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .push      (push),
    .result    (result)
  );

  gfcr_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .result        (result),
    .room          (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[rtl/core/gfcr_in_stage.sv]
module gfcr_in_stage
  import gfcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
  input  logic       s_axis_tuser,   // [0] opcode
  input  logic       take,
  output logic       item_valid,
  output gfcr_item_t item
);

  // The register can load when empty or when its beat is taken this cycle.
  assign s_axis_tready = !item_valid || take;

  // Valid flag of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  // Payload of the input register.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.opcode     <= s_axis_tuser;
      item.byte_value <= s_axis_tdata;
    end
  end

endmodule

[rtl/core/gfcr_frame_core.sv]
module gfcr_frame_core
  import gfcr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         fire,
  input  gfcr_item_t   item,
  output logic         push,
  output gfcr_result_t result
);

  localparam int CntW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME_BYTES);
  localparam logic [CntW-1:0] CntMin = CntW'(MIN_FRAME_BYTES);

  logic [15:0]     gap_ticks;
  logic [CntW-1:0] count, count_next;
  logic [15:0]     crc_last, crc_last_next;
  logic [15:0]     crc_lag1, crc_lag1_next;
  logic [15:0]     crc_lag2, crc_lag2_next;
  logic [7:0]      newest, newest_next;
  logic [7:0]      previous, previous_next;
  logic [15:0]     idle, idle_next;
  logic [15:0]     idle_inc;
  logic [15:0]     rx_crc;
  logic [CntW+6:0] count_wide;
  logic            close;

  // Gap register, written from the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks <= GAP_RESET;
    end else if (cfg_we) begin
      gap_ticks <= cfg_wdata;
    end
  end

  assign idle_inc   = (idle == IDLE_MAX) ? idle : idle + 16'd1;
  assign rx_crc     = {newest, previous};
  assign count_wide = {7'd0, count};
  assign close      = fire && (item.opcode == OP_TICK) &&
                      (count >= CntMin) && (idle_inc >= gap_ticks);

  // Next-state logic for one beat.
  always_comb begin
    count_next    = count;
    crc_last_next = crc_last;
    crc_lag1_next = crc_lag1;
    crc_lag2_next = crc_lag2;
    newest_next   = newest;
    previous_next = previous;
    idle_next     = idle;
    if (fire) begin
      if (item.opcode == OP_BYTE) begin
        idle_next = 16'd0;
        // A full frame drops the byte but still restarts the idle timer.
        if (count < CntMax) begin
          crc_lag2_next = crc_lag1;
          crc_lag1_next = crc_last;
          crc_last_next = crc16_feed(crc_last, item.byte_value);
          previous_next = newest;
          newest_next   = item.byte_value;
          count_next    = count + CntW'(1);
        end
      end else begin
        idle_next = idle_inc;
        if (close) begin
          count_next    = '0;
          crc_last_next = CRC_INIT;
          crc_lag1_next = CRC_INIT;
          crc_lag2_next = CRC_INIT;
        end
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      crc_last <= CRC_INIT;
      crc_lag1 <= CRC_INIT;
      crc_lag2 <= CRC_INIT;
      newest   <= 8'd0;
      previous <= 8'd0;
      idle     <= 16'd0;
    end else begin
      count    <= count_next;
      crc_last <= crc_last_next;
      crc_lag1 <= crc_lag1_next;
      crc_lag2 <= crc_lag2_next;
      newest   <= newest_next;
      previous <= previous_next;
      idle     <= idle_next;
    end
  end

  // Report of the frame that closes on this beat.
  assign push                = close;
  assign result.crc_ok       = (rx_crc == crc_lag2);
  assign result.frame_length = count_wide[6:0];
  assign result.crc_received = rx_crc;
  assign result.crc_computed = crc_lag2;

endmodule

[rtl/core/gfcr_out_stage.sv]
module gfcr_out_stage
  import gfcr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  gfcr_result_t           result,
  output logic                   room,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [6:0] frame_length, [22:7] crc_received,
                                                // [38:23] crc_computed, [39] zero
  output logic                   m_axis_tuser   // [0] crc_ok
);

  logic [1:0]   fill;
  gfcr_result_t main_q;
  gfcr_result_t skid_q;
  logic         pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign room          = (fill != 2'd2);
  assign m_axis_tvalid = (fill != 2'd0);
  assign m_axis_tuser  = main_q.crc_ok;
  assign m_axis_tdata  = {1'b0, main_q.crc_computed, main_q.crc_received,
                          main_q.frame_length};

  // Occupancy of the two-entry output buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (push && !pop) begin
      fill <= fill + 2'd1;
    end else if (pop && !push) begin
      fill <= fill - 2'd1;
    end
  end

  // Main and skid entries; the head is always in the main entry.
  always_ff @(posedge clk) begin
    if (push && (fill == 2'd0 || (pop && fill == 2'd1))) begin
      main_q <= result;
    end else if (pop && fill == 2'd2) begin
      main_q <= skid_q;
    end
    if (push && fill == 2'd1 && !pop) begin
      skid_q <= result;
    end
  end

endmodule

[rtl/core/gfcr_checker.sv]
`include "assert_macros.svh"

module gfcr_checker
  import gfcr_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  logic [15:0] crc_rx;
  logic [15:0] crc_calc;

  // The two CRC fields of the report beat.
  assign crc_rx   = m_axis_tdata[22:7];
  assign crc_calc = m_axis_tdata[38:23];

  // A stalled report stays valid and unchanged.
  `ASSERT_NEXT(a_out_hold_valid, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_NEXT(a_out_hold_data, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // The match flag agrees with the two CRC fields of the same beat.
  `ASSERT_IMPLY(a_crc_flag, clk, rst, m_axis_tvalid, m_axis_tuser == (crc_rx == crc_calc))

  // Reset leaves no report pending.
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_axis_tvalid)

endmodule

bind gap_framed_crc16_receiver_top gfcr_checker u_gfcr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
